/* hw/rtl/lane_line_slope_averager_macros.svh */
// Assertion macros for the lane line averager.
// Used by the top level; no other dependencies.
`ifndef LANE_LINE_SLOPE_AVERAGER_MACROS_SVH
`define LANE_LINE_SLOPE_AVERAGER_MACROS_SVH
`ifndef SYNTH
`define LLSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LLSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LLSA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LLSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/llsa_pkg.sv */
// Shared types and constants for the lane line averager.
// No dependencies.
`timescale 1ns / 1ps
package llsa_pkg;
   localparam int COORD_W = 12;
   localparam int OUT_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_RISE    = 1'b1;
   // Divider jobs
   typedef enum logic [2:0] {
      JOB_SLOPE, JOB_ICPT, JOB_LB, JOB_LT, JOB_RB, JOB_RT
   } job_type;
   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_DIV_START, ST_DIV_WAIT, ST_ACCUM, ST_RESULT, ST_OUT
   } state_type;
   // Controller to datapath
   typedef struct packed {
      logic    load;
      logic    div_start;
      job_type job;
      logic    store_q;
      logic    accum;
      logic    out_load;
   } cmd_type;
   // Datapath to controller
   typedef struct packed {
      logic dx_zero;
      logic last;
      logic div_done;
   } sts_type;
endpackage

/* hw/rtl/llsa_divider.sv */
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
module llsa_divider #(
   parameter int W = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] dividend,
   input  logic signed [W-1:0] divisor,
   output logic                done,
   output logic signed [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [W:0] trial;
   logic [W-1:0] rsh;

   // Shift one bit a cycle
   always_comb begin
      rsh   = {rem_ff[W-2:0], quo_ff[W-1]};
      trial = {1'b0, rsh} - {1'b0, den_ff};
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend[W-1] ? W'(-dividend) : dividend;
         den_in = divisor[W-1] ? W'(-divisor) : divisor;
         neg_in = dividend[W-1] ^ divisor[W-1];
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         rem_in = trial[W] ? rsh : trial[W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? W'(-quo_ff) : quo_ff;
endmodule

/* hw/rtl/llsa_datapath.sv */
// Datapath: segment registers, side sums, shared divider and result word.
// Depends on llsa_pkg and llsa_divider.
`timescale 1ns / 1ps
module llsa_datapath
   import llsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 256,
   parameter int COORD_BITS   = 12,
   parameter int FRAC_BITS    = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [COORD_W-1:0]       x_start,
   input  logic [COORD_W-1:0]       y_start,
   input  logic [COORD_W-1:0]       x_end,
   input  logic [COORD_W-1:0]       y_end,
   input  logic                     frame_last,
   input  logic [COORD_W-1:0]       frame_height,
   input  logic [COORD_W-1:0]       line_rise,
   output logic signed [OUT_W-1:0]  left_x_bottom,
   output logic signed [OUT_W-1:0]  left_x_top,
   output logic                     left_valid,
   output logic signed [OUT_W-1:0]  right_x_bottom,
   output logic signed [OUT_W-1:0]  right_x_top,
   output logic                     right_valid,
   output logic [COORD_W-1:0]       y_bottom,
   output logic signed [COORD_W:0]  y_top
);
   localparam int DW = 64;
   localparam int NW = $clog2(MAX_SEGMENTS + 1);
   // Coordinate bits actually kept from the port fields
   localparam int CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

   logic [CB-1:0] xs_ff, ys_ff, xe_ff, ye_ff;
   logic last_ff;
   logic signed [DW-1:0] m_ff, b_ff;
   logic [DW-1:0] ls_ff, lb_ff, rs_ff, rb_ff;
   logic [NW-1:0] lc_ff, rc_ff;
   logic signed [DW-1:0] dxs, dys, prod, num, den, quo;
   logic signed [2*CB+2:0] prod_n;
   logic signed [DW-1:0] yb, yt, ybn, ytn, rbn, rtn;
   logic signed [COORD_W+NW+1:0] lbp, ltp, rbp, rtp;
   logic signed [DW-1:0] lxb_ff, lxt_ff, rxb_ff;
   logic div_done;
   logic signed [OUT_W-1:0] lxb_o, lxt_o, rxb_o, rxt_o;
   logic lv_o, rv_o;
   logic [COORD_W-1:0] yb_o;
   logic signed [COORD_W:0] yt_o;

   // Hold segment on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xs_ff <= x_start[CB-1:0];
         ys_ff <= y_start[CB-1:0];
         xe_ff <= x_end[CB-1:0];
         ye_ff <= y_end[CB-1:0];
         last_ff <= frame_last;
      end
   end

   assign dxs    = DW'($signed({1'b0, xe_ff})) - DW'($signed({1'b0, xs_ff}));
   assign dys    = DW'($signed({1'b0, ye_ff})) - DW'($signed({1'b0, ys_ff}));
   assign prod_n = $signed({1'b0, ys_ff}) * $signed({1'b0, xe_ff})
                 - $signed({1'b0, ye_ff}) * $signed({1'b0, xs_ff});
   assign prod   = DW'(prod_n);
   assign yb   = DW'($signed({1'b0, frame_height}));
   assign yt   = yb - DW'($signed({1'b0, line_rise}));
   // Row times count on narrow multipliers, then scale
   assign lbp  = $signed(yb[COORD_W:0]) * $signed({1'b0, lc_ff});
   assign ltp  = $signed(yt[COORD_W:0]) * $signed({1'b0, lc_ff});
   assign rbp  = $signed(yb[COORD_W:0]) * $signed({1'b0, rc_ff});
   assign rtp  = $signed(yt[COORD_W:0]) * $signed({1'b0, rc_ff});
   assign ybn  = DW'(lbp) <<< FRAC_BITS;
   assign ytn  = DW'(ltp) <<< FRAC_BITS;
   assign rbn  = DW'(rbp) <<< FRAC_BITS;
   assign rtn  = DW'(rtp) <<< FRAC_BITS;

   // Pick dividend and divisor for the job
   always_comb begin
      case (cmd.job)
         JOB_SLOPE: begin num = dys <<< FRAC_BITS;  den = dxs; end
         JOB_ICPT:  begin num = prod <<< FRAC_BITS; den = dxs; end
         JOB_LB:    begin num = ybn - $signed(lb_ff); den = $signed(ls_ff); end
         JOB_LT:    begin num = ytn - $signed(lb_ff); den = $signed(ls_ff); end
         JOB_RB:    begin num = rbn - $signed(rb_ff); den = $signed(rs_ff); end
         JOB_RT:    begin num = rtn - $signed(rb_ff); den = $signed(rs_ff); end
         default:   begin num = '0; den = 64'sd1; end
      endcase
   end

   llsa_divider #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(num), .divisor(den), .done(div_done), .quotient(quo)
   );

   // Capture quotient; the last one goes straight into the result word
   always_ff @(posedge clock) begin
      if (cmd.store_q) begin
         case (cmd.job)
            JOB_SLOPE: m_ff <= quo;
            JOB_ICPT:  b_ff <= quo;
            JOB_LB:    lxb_ff <= quo;
            JOB_LT:    lxt_ff <= quo;
            JOB_RB:    rxb_ff <= quo;
            default:   m_ff <= m_ff;
         endcase
      end
   end

   // Accumulate per side; clear after frame end
   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         ls_ff <= '0; lb_ff <= '0; lc_ff <= '0;
         rs_ff <= '0; rb_ff <= '0; rc_ff <= '0;
      end else if (cmd.accum) begin
         if (m_ff[DW-1]) begin
            if (lc_ff < NW'(MAX_SEGMENTS)) begin
               ls_ff <= ls_ff + m_ff; lb_ff <= lb_ff + b_ff; lc_ff <= lc_ff + 1'b1;
            end
         end else if (rc_ff < NW'(MAX_SEGMENTS)) begin
            rs_ff <= rs_ff + m_ff; rb_ff <= rb_ff + b_ff; rc_ff <= rc_ff + 1'b1;
         end
      end
   end

   function automatic logic signed [OUT_W-1:0] sat(input logic signed [DW-1:0] v);
      if (v > 64'sd32767) return 16'sh7fff;
      if (v < -64'sd32768) return 16'sh8000;
      return v[OUT_W-1:0];
   endfunction

   // Load the result word
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         lv_o  <= (lc_ff != '0) && (ls_ff != '0);
         rv_o  <= (rc_ff != '0) && (rs_ff != '0);
         lxb_o <= ((lc_ff != '0) && (ls_ff != '0)) ? sat(lxb_ff) : '0;
         lxt_o <= ((lc_ff != '0) && (ls_ff != '0)) ? sat(lxt_ff) : '0;
         rxb_o <= ((rc_ff != '0) && (rs_ff != '0)) ? sat(rxb_ff) : '0;
         rxt_o <= ((rc_ff != '0) && (rs_ff != '0)) ? sat(quo) : '0;
         yb_o  <= frame_height;
         yt_o  <= yt[COORD_W:0];
      end
   end

   assign sts.dx_zero  = (xs_ff == xe_ff);
   assign sts.last     = last_ff;
   assign sts.div_done = div_done;
   assign left_x_bottom = lxb_o;  assign left_x_top = lxt_o;  assign left_valid = lv_o;
   assign right_x_bottom = rxb_o; assign right_x_top = rxt_o; assign right_valid = rv_o;
   assign y_bottom = yb_o;        assign y_top = yt_o;
endmodule

/* hw/rtl/llsa_control.sv */
// Controller: sequences divider jobs per segment and at frame end.
// Depends on llsa_pkg.
`timescale 1ns / 1ps
module llsa_control
   import llsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   state_type state_ff, state_in;
   job_type job_ff, job_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            job_in = JOB_SLOPE;
            state_in = sts.dx_zero ? (sts.last ? ST_RESULT : ST_IDLE) : ST_DIV_START;
         end
         ST_RESULT: begin
            job_in = JOB_LB;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (sts.div_done) begin
            case (job_ff)
               JOB_SLOPE: begin job_in = JOB_ICPT; state_in = ST_DIV_START; end
               JOB_ICPT:  state_in = ST_ACCUM;
               JOB_LB:    begin job_in = JOB_LT; state_in = ST_DIV_START; end
               JOB_LT:    begin job_in = JOB_RB; state_in = ST_DIV_START; end
               JOB_RB:    begin job_in = JOB_RT; state_in = ST_DIV_START; end
               default:   state_in = ST_OUT;
            endcase
         end
         ST_ACCUM: state_in = sts.last ? ST_RESULT : ST_IDLE;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      cmd.job = job_ff;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      cmd.load = (state_ff == ST_IDLE) && req_valid;
      cmd.div_start = (state_ff == ST_DIV_START);
      cmd.store_q = (state_ff == ST_DIV_WAIT) && sts.div_done;
      cmd.accum = (state_ff == ST_ACCUM);
      cmd.out_load = (state_ff == ST_DIV_WAIT) && sts.div_done && (job_ff == JOB_RT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff <= JOB_SLOPE;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
      end
   end
endmodule

/* hw/rtl/lane_line_slope_averager.sv */
// Lane line averager: takes one segment word at a time; a segment with a
// nonzero dx needs two 64-step divisions on the shared restoring divider
// and the frame's last segment four more for the x values. The
// result word waits in an output register; no new segment is taken until
// it is read. Depends on llsa_pkg, llsa_control, llsa_datapath.
`timescale 1ns / 1ps
`include "lane_line_slope_averager_macros.svh"
module lane_line_slope_averager
   import llsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 256,
   parameter int COORD_BITS   = 12,
   parameter int FRAC_BITS    = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_W-1:0]      req_x_start,
   input  logic [COORD_W-1:0]      req_y_start,
   input  logic [COORD_W-1:0]      req_x_end,
   input  logic [COORD_W-1:0]      req_y_end,
   input  logic                    req_frame_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_left_x_bottom,
   output logic signed [OUT_W-1:0] rsp_left_x_top,
   output logic                    rsp_left_valid,
   output logic signed [OUT_W-1:0] rsp_right_x_bottom,
   output logic signed [OUT_W-1:0] rsp_right_x_top,
   output logic                    rsp_right_valid,
   output logic [COORD_W-1:0]      rsp_y_bottom,
   output logic signed [COORD_W:0] rsp_y_top,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]             csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic [COORD_W-1:0] fh_ff, lr_ff;

   // Configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fh_ff <= 12'd720;
         lr_ff <= 12'd150;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_HEIGHT: fh_ff <= csr_data[COORD_W-1:0];
            CSR_LINE_RISE:    lr_ff <= csr_data[COORD_W-1:0];
            default:          fh_ff <= fh_ff;
         endcase
      end
   end

   llsa_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .sts(sts)
   );

   llsa_datapath #(
      .MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .x_start(req_x_start), .y_start(req_y_start), .x_end(req_x_end),
      .y_end(req_y_end), .frame_last(req_frame_last),
      .frame_height(fh_ff), .line_rise(lr_ff),
      .left_x_bottom(rsp_left_x_bottom), .left_x_top(rsp_left_x_top),
      .left_valid(rsp_left_valid), .right_x_bottom(rsp_right_x_bottom),
      .right_x_top(rsp_right_x_top), .right_valid(rsp_right_valid),
      .y_bottom(rsp_y_bottom), .y_top(rsp_y_top)
   );

   `LLSA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `LLSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LLSA_ASSERT_NEXT(a_load_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

/* tb/sv/tb_lane_line_slope_averager.sv */
// Self-checking testbench for lane_line_slope_averager: random segment frames,
// a fixed-point lane predictor and an in-order result check. Depends on llsa_pkg.
`timescale 1ns / 1ps
module tb_lane_line_slope_averager;
   import llsa_pkg::*;

   localparam int MAX_SEG   = 256;
   localparam int FRAC      = 20;
   localparam int LIMIT     = 3000000;
   localparam int TAIL      = 600;

   typedef struct packed {
      logic [11:0] xs, ys, xe, ye;
      logic        last;
   } seg_word_type;

   typedef struct packed {
      logic signed [15:0] lxb, lxt;
      logic               lv;
      logic signed [15:0] rxb, rxt;
      logic               rv;
      logic [11:0]        yb;
      logic signed [12:0] yt;
   } lane_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [11:0] req_x_start = '0, req_y_start = '0, req_x_end = '0, req_y_end = '0;
   logic req_frame_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_left_x_bottom, rsp_left_x_top, rsp_right_x_bottom, rsp_right_x_top;
   logic rsp_left_valid, rsp_right_valid;
   logic [11:0] rsp_y_bottom;
   logic signed [12:0] rsp_y_top;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   lane_line_slope_averager dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [11:0] cfg_height = 12'd720, cfg_rise = 12'd150;
   logic [63:0] l_msum, l_bsum, r_msum, r_bsum;
   int unsigned l_cnt, r_cnt;

   seg_word_type  seg_q[$];
   lane_word_type lane_q[$];
   int  errors = 0;
   int  cycles = 0;
   bit  calm = 1'b0;
   int  hold_off = 0;
   bit  src_pause = 1'b0;

   function automatic longint trunc_div(longint a, longint b);
      longint ua, ub, q;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      q = ua / ub;
      return ((a < 0) != (b < 0)) ? -q : q;
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   task automatic side_x(input logic [63:0] ms, bs, input int unsigned n, input longint yb,
                         yt, output logic [15:0] xb, xt, output logic v);
      longint s;
      logic [63:0] nb, nt;
      s = ms;
      if (n == 0 || s == 0) begin
         xb = '0; xt = '0; v = 1'b0;
      end else begin
         nb = yb * n * (64'd1 << FRAC) - bs;
         nt = yt * n * (64'd1 << FRAC) - bs;
         xb = clamp16(trunc_div(nb, s));
         xt = clamp16(trunc_div(nt, s));
         v = 1'b1;
      end
   endtask

   // Advance the lane sums by one segment; queue a result on the last one
   task automatic predict_lane(input seg_word_type w);
      longint dx, m, b, yb, yt;
      lane_word_type r;
      dx = longint'(w.xe) - longint'(w.xs);
      if (dx != 0) begin
         m = trunc_div((longint'(w.ye) - longint'(w.ys)) * (64'sd1 << FRAC), dx);
         b = trunc_div((longint'(w.ys) * w.xe - longint'(w.ye) * w.xs) * (64'sd1 << FRAC), dx);
         if (m < 0) begin
            if (l_cnt < MAX_SEG) begin
               l_msum += m; l_bsum += b; l_cnt++;
            end
         end else if (r_cnt < MAX_SEG) begin
            r_msum += m; r_bsum += b; r_cnt++;
         end
      end
      if (w.last) begin
         yb = cfg_height;
         yt = longint'(cfg_height) - longint'(cfg_rise);
         side_x(l_msum, l_bsum, l_cnt, yb, yt, r.lxb, r.lxt, r.lv);
         side_x(r_msum, r_bsum, r_cnt, yb, yt, r.rxb, r.rxt, r.rv);
         r.yb = cfg_height;
         r.yt = yt[12:0];
         lane_q.push_back(r);
         l_msum = 0; l_bsum = 0; l_cnt = 0;
         r_msum = 0; r_bsum = 0; r_cnt = 0;
      end
   endtask

   // Driver: offer queued segments, idle at random
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         predict_lane(seg_q.pop_front());
      end
      if (!reset && (!req_valid || req_ready)) begin
         if (seg_q.size() > 0 && !src_pause && (calm || $urandom_range(99) >= 18)) begin
            req_valid      <= 1'b1;
            req_x_start    <= seg_q[0].xs;
            req_y_start    <= seg_q[0].ys;
            req_x_end      <= seg_q[0].xe;
            req_y_end      <= seg_q[0].ye;
            req_frame_last <= seg_q[0].last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: accept results, stall at random or for a long hold-off
   always @(posedge clock) begin
      lane_word_type got, want;
      cycles <= cycles + 1;
      if (rsp_valid && rsp_ready) begin
         got = '{rsp_left_x_bottom, rsp_left_x_top, rsp_left_valid, rsp_right_x_bottom,
                 rsp_right_x_top, rsp_right_valid, rsp_y_bottom, rsp_y_top};
         if (lane_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, got);
         end else begin
            want = lane_q.pop_front();
            if (got.lxb !== want.lxb) begin errors++;
               $display("%0t: left_x_bottom exp %0d got %0d", $time, want.lxb, got.lxb); end
            if (got.lxt !== want.lxt) begin errors++;
               $display("%0t: left_x_top exp %0d got %0d", $time, want.lxt, got.lxt); end
            if (got.lv !== want.lv) begin errors++;
               $display("%0t: left_valid exp %0d got %0d", $time, want.lv, got.lv); end
            if (got.rxb !== want.rxb) begin errors++;
               $display("%0t: right_x_bottom exp %0d got %0d", $time, want.rxb, got.rxb); end
            if (got.rxt !== want.rxt) begin errors++;
               $display("%0t: right_x_top exp %0d got %0d", $time, want.rxt, got.rxt); end
            if (got.rv !== want.rv) begin errors++;
               $display("%0t: right_valid exp %0d got %0d", $time, want.rv, got.rv); end
            if (got.yb !== want.yb) begin errors++;
               $display("%0t: y_bottom exp %0d got %0d", $time, want.yb, got.yb); end
            if (got.yt !== want.yt) begin errors++;
               $display("%0t: y_top exp %0d got %0d", $time, want.yt, got.yt); end
         end
      end
      if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && (calm || $urandom_range(99) >= 18);
      end
   end

   // Timeout
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("lane_line_slope_averager: mismatch");
         $finish;
      end
   end

   function automatic seg_word_type rand_seg(input bit last);
      seg_word_type w;
      w.xs = 12'($urandom); w.ys = 12'($urandom);
      w.xe = 12'($urandom); w.ye = 12'($urandom);
      if ($urandom_range(9) == 0) w.xe = w.xs;
      w.last = last;
      return w;
   endfunction

   task automatic add_seg(input logic [11:0] xs, ys, xe, ye, input bit last);
      seg_word_type w;
      w = '{xs, ys, xe, ye, last};
      seg_q.push_back(w);
   endtask

   task automatic wait_drain;
      while (seg_q.size() > 0 || req_valid || lane_q.size() > 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAME_HEIGHT) cfg_height = val[11:0];
      else cfg_rise = val[11:0];
   endtask

   initial begin
      int n, k;
      l_msum = 0; l_bsum = 0; l_cnt = 0; r_msum = 0; r_bsum = 0; r_cnt = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // Directed: reset registers, extremes, vertical, zero slope, empty sides
      add_seg(12'd0, 12'd0, 12'd4095, 12'd4095, 1'b0);
      add_seg(12'd0, 12'd4095, 12'd4095, 12'd0, 1'b1);
      add_seg(12'd100, 12'd5, 12'd100, 12'd900, 1'b1);
      add_seg(12'd7, 12'd7, 12'd7, 12'd7, 1'b1);
      add_seg(12'd0, 12'd10, 12'd4095, 12'd10, 1'b1);
      add_seg(12'd0, 12'd10, 12'd4095, 12'd11, 1'b1);
      add_seg(12'd4095, 12'd0, 12'd0, 12'd4095, 1'b0);
      add_seg(12'd10, 12'd4095, 12'd11, 12'd0, 1'b1);
      add_seg(12'd2000, 12'd0, 12'd2001, 12'd4095, 1'b1);
      wait_drain();
      csr_write(CSR_FRAME_HEIGHT, 32'hFFFF_F001);
      csr_write(CSR_LINE_RISE, 32'h0000_0FFF);
      add_seg(12'd300, 12'd700, 12'd600, 12'd400, 1'b0);
      add_seg(12'd700, 12'd400, 12'd1000, 12'd700, 1'b1);
      add_seg(12'd1, 12'd2, 12'd3, 12'd4, 1'b1);
      wait_drain();
      csr_write(CSR_FRAME_HEIGHT, 32'd0);
      csr_write(CSR_LINE_RISE, 32'd0);
      add_seg(12'd300, 12'd700, 12'd600, 12'd400, 1'b0);
      add_seg(12'd700, 12'd400, 12'd1000, 12'd700, 1'b1);
      wait_drain();
      // Long frame: 260 segments, split between the sides by slope sign
      csr_write(CSR_FRAME_HEIGHT, 32'd4095);
      csr_write(CSR_LINE_RISE, 32'd4095);
      calm = 1'b1;
      for (int i = 0; i < 260; i++) add_seg(12'($urandom_range(2000)),
                                          12'($urandom_range(4095)), 12'd3000,
                                          12'($urandom_range(4095)), i == 259);
      wait_drain();
      calm = 1'b0;
      // Random frames across settings; one long receiver hold-off
      for (int p = 0; p < 4; p++) begin
         if (p > 0) begin
            csr_write(CSR_FRAME_HEIGHT, (p == 3) ? 32'd1 : $urandom);
            csr_write(CSR_LINE_RISE, $urandom);
         end
         n = 0;
         while (n < 60) begin
            k = $urandom_range(6, 1);
            for (int i = 0; i < k; i++) seg_q.push_back(rand_seg(i == k - 1));
            n += k;
         end
         if (p == 1) begin
            calm = 1'b1;
            hold_off = 2000;
            wait_drain();
            calm = 1'b0;
         end else begin
            wait_drain();
         end
      end
      if (errors == 0) begin
         $display("lane_line_slope_averager: match");
      end else begin
         $display("lane_line_slope_averager: mismatch");
      end
      $finish;
   end
endmodule
